@@ hw/rtl/range_flag_completion_tracker_macros.svh @@
// ----------------------------------------------------------------------------
// Range flag completion tracker: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RANGE_FLAG_COMPLETION_TRACKER_MACROS_SVH
`define RANGE_FLAG_COMPLETION_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RFCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RFCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RFCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define RFCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hw/rtl/rfct_pkg.sv @@
// ----------------------------------------------------------------------------
// rfct_pkg
// Shared constants, codes and types of the range flag completion tracker.
// ----------------------------------------------------------------------------
package rfct_pkg;

    // flag store size; power of two (FIFO pointers wrap by mask)
    localparam int FLAG_BITS = 64;
    localparam int MAX_RANKS = 16;
    localparam int MAX_OUT   = 64;
    localparam int FLAG_W    = $clog2(FLAG_BITS);
    localparam int FILL_W    = FLAG_W + 1;
    localparam int CNT_W     = 7;
    localparam int OPEN_W    = 7;
    localparam int TASK_W    = 64;
    localparam int KIND_W    = 3;
    localparam int POS_W     = 12;   // tile*rank_count + rank + span
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    localparam logic [OPEN_W-1:0] OPEN_MAX = 7'd127;

    // request codes
    localparam logic [1:0] REQ_ENQ  = 2'd0;
    localparam logic [1:0] REQ_FLAG = 2'd1;
    localparam logic [1:0] REQ_POLL = 2'd2;
    localparam logic [1:0] REQ_RSVD = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACC  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REJ  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NONE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OVF  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_RANK   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT = 1'd1;

    // classified command ops
    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_REJ  = 2'd1;
    localparam logic [1:0] OP_FLAG = 2'd2;
    localparam logic [1:0] OP_POLL = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [TASK_W-1:0] task_id;
        logic [FLAG_W-1:0] start;     // first bit, or flag bit for OP_FLAG
        logic [FLAG_W-1:0] stop;
        logic [CNT_W-1:0]  span_cnt;
        logic              local_hit;
        logic [FLAG_W-1:0] local_idx;
    } t_cmd;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [OPEN_W-1:0] open_cnt;
    } t_back_stat;

endpackage

@@ hw/rtl/rfct_in_if.sv @@
// ----------------------------------------------------------------------------
// rfct_in_if
// Request channel: valid/ready plus request payload.
// ----------------------------------------------------------------------------
interface rfct_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] task_id;
    logic [5:0]  tile_index;
    logic [3:0]  rank_first;
    logic [4:0]  rank_span;
    logic [5:0]  flag_index;

    modport source (output valid, req_type, task_id, tile_index, rank_first,
                    rank_span, flag_index, input ready);
    modport sink   (input valid, req_type, task_id, tile_index, rank_first,
                    rank_span, flag_index, output ready);
endinterface

@@ hw/rtl/rfct_out_if.sv @@
// ----------------------------------------------------------------------------
// rfct_out_if
// Result channel: valid/ready plus result payload.
// ----------------------------------------------------------------------------
interface rfct_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] done_task;
    logic        last;

    modport source (output valid, kind, done_task, last, input ready);
    modport sink   (input valid, kind, done_task, last, output ready);
endinterface

@@ hw/rtl/rfct_front.sv @@
// ----------------------------------------------------------------------------
// rfct_front
// Accepts request beats, computes flag ranges, classifies into commands.
// ----------------------------------------------------------------------------
module rfct_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [3:0]          i_own_rank,
    input  logic [4:0]          i_rank_count,
    rfct_in_if.sink             i_in,
    output logic                o_cmd_valid,
    output rfct_pkg::t_cmd      o_cmd,
    input  logic                i_cmd_ready
);
    logic [10:0]               prod;
    logic [rfct_pkg::POS_W-1:0] start_w;
    logic [rfct_pkg::POS_W-1:0] stop_w;
    logic [rfct_pkg::POS_W-1:0] local_w;
    logic [5:0]                rank_end;
    logic                      reject;
    logic                      accept;
    rfct_pkg::t_cmd            cmd_w;
    logic                      r_valid;
    rfct_pkg::t_cmd            r_cmd;

    assign prod     = 11'(i_in.tile_index) * 11'(i_rank_count);
    assign start_w  = rfct_pkg::POS_W'(prod) + rfct_pkg::POS_W'(i_in.rank_first);
    assign stop_w   = start_w + rfct_pkg::POS_W'(i_in.rank_span) - rfct_pkg::POS_W'(1);
    assign local_w  = rfct_pkg::POS_W'(prod) + rfct_pkg::POS_W'(i_own_rank);
    assign rank_end = 6'(i_in.rank_first) + 6'(i_in.rank_span);
    assign reject   = (i_in.rank_span == 5'd0)
                   || (rank_end > 6'(rfct_pkg::MAX_RANKS))
                   || (stop_w >= rfct_pkg::POS_W'(rfct_pkg::FLAG_BITS));

    always_comb begin
        cmd_w           = '0;
        cmd_w.task_id   = i_in.task_id;
        cmd_w.start     = start_w[rfct_pkg::FLAG_W-1:0];
        cmd_w.stop      = stop_w[rfct_pkg::FLAG_W-1:0];
        cmd_w.span_cnt  = rfct_pkg::CNT_W'(i_in.rank_span);
        cmd_w.local_hit = (local_w >= start_w) && (local_w <= stop_w);
        cmd_w.local_idx = local_w[rfct_pkg::FLAG_W-1:0];
        unique case (i_in.req_type)
            rfct_pkg::REQ_ENQ:  cmd_w.op = reject ? rfct_pkg::OP_REJ : rfct_pkg::OP_ENQ;
            rfct_pkg::REQ_FLAG: begin
                cmd_w.op    = rfct_pkg::OP_FLAG;
                cmd_w.start = i_in.flag_index[rfct_pkg::FLAG_W-1:0];
            end
            rfct_pkg::REQ_POLL: cmd_w.op = rfct_pkg::OP_POLL;
            default:            cmd_w.op = rfct_pkg::OP_POLL;   // dropped below
        endcase
    end

    assign i_in.ready = !r_valid || i_cmd_ready;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= (i_in.req_type != rfct_pkg::REQ_RSVD);
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= cmd_w;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;
endmodule

@@ hw/rtl/rfct_cmd_q.sv @@
// ----------------------------------------------------------------------------
// rfct_cmd_q
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module rfct_cmd_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  rfct_pkg::t_cmd i_push_cmd,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output rfct_pkg::t_cmd o_pop_cmd,
    input  logic           i_pop_ready
);
    rfct_pkg::t_cmd               r_slot [rfct_pkg::Q_DEPTH];
    logic [rfct_pkg::Q_PTR_W-1:0] r_wr;
    logic [rfct_pkg::Q_PTR_W-1:0] r_rd;
    logic [rfct_pkg::Q_PTR_W:0]   r_count;
    logic                         push;
    logic                         pop;

    assign o_push_ready = (r_count != (rfct_pkg::Q_PTR_W+1)'(rfct_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slot[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            if (push && !pop) r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_push_cmd;
        end
    end
endmodule

@@ hw/rtl/rfct_back.sv @@
// ----------------------------------------------------------------------------
// rfct_back
// Executes commands: flag store, task tables, ready FIFO, result output.
// ----------------------------------------------------------------------------
module rfct_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  rfct_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_ready,
    rfct_out_if.source           o_out,
    output rfct_pkg::t_back_stat o_stat
);
    localparam int FB = rfct_pkg::FLAG_BITS;
    localparam int FW = rfct_pkg::FLAG_W;
    localparam int CW = rfct_pkg::CNT_W;
    localparam int TW = rfct_pkg::TASK_W;
    localparam int KW = rfct_pkg::KIND_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ENQ_LOOP = 4'd1;
    localparam logic [3:0] S_ENQ_FIN  = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_DRN_INIT = 4'd4;
    localparam logic [3:0] S_DRN_POP  = 4'd5;
    localparam logic [3:0] S_DRN_OFF  = 4'd6;
    localparam logic [3:0] S_DRN_HEAD = 4'd7;
    localparam logic [3:0] S_DRN_CNT  = 4'd8;
    localparam logic [3:0] S_POLL_END = 4'd9;
    localparam logic [3:0] S_ONE      = 4'd10;
    localparam logic [3:0] S_FLUSH    = 4'd11;

    logic [3:0]                  r_state;
    rfct_pkg::t_cmd              r_cmd;
    logic [FW-1:0]               r_i;
    logic [FB-1:0]               r_window;
    logic [FB-1:0]               r_pending;
    logic [rfct_pkg::FILL_W-1:0] r_fill;
    logic [FW-1:0]               r_head;
    logic [rfct_pkg::OPEN_W-1:0] r_open;
    logic                        r_ovf;
    logic [rfct_pkg::FILL_W-1:0] r_todo;
    logic [rfct_pkg::FILL_W-1:0] r_nres;
    logic [KW-1:0]               r_one_kind;
    logic [FW-1:0]               r_idx;
    logic [FW-1:0]               r_head_e;
    logic                        r_hold_v;
    logic [KW-1:0]               r_hold_kind;
    logic [TW-1:0]               r_hold_task;
    logic                        r_out_v;
    logic [KW-1:0]               r_out_kind;
    logic [TW-1:0]               r_out_task;
    logic                        r_out_last;

    // memories and their registered read data
    logic [TW-1:0] m_task [FB];
    logic [CW-1:0] m_cnt  [FB];
    logic [FW-1:0] m_off  [FB];
    logic [FW-1:0] m_fifo [FB];
    logic [FB-1:0] r_cnt_vld;
    logic [FB-1:0] r_off_vld;
    logic [TW-1:0] r_task_rd;
    logic [CW-1:0] r_cnt_rd;
    logic          r_cnt_rd_v;
    logic [FW-1:0] r_off_rd;
    logic          r_off_rd_v;
    logic [FW-1:0] r_fifo_rd;

    logic          slot_free;
    logic          emit_req;
    logic [KW-1:0] emit_kind;
    logic [TW-1:0] emit_task;
    logic          flush_req;
    logic          stall;
    logic          out_load;
    logic          push_ok;
    logic [FW-1:0] tail;
    logic [FW-1:0] off_w;
    logic [FW-1:0] head_e_w;
    logic [CW-1:0] cnt_w;
    logic [rfct_pkg::FILL_W-1:0] limit;
    logic          fifo_we;
    logic [FW-1:0] fifo_wd;
    logic          cnt_we;
    logic [FW-1:0] cnt_wa;
    logic [CW-1:0] cnt_wd;
    logic          off_we;
    logic          task_we;

    assign slot_free = !r_out_v || o_out.ready;
    assign push_ok   = (r_fill < rfct_pkg::FILL_W'(FB));
    assign tail      = r_head + r_fill[FW-1:0];
    assign off_w     = r_off_rd_v ? r_off_rd : '0;
    assign head_e_w  = (off_w <= r_idx) ? (r_idx - off_w) : r_idx;
    assign cnt_w     = r_cnt_rd_v ? r_cnt_rd : '0;
    assign limit     = r_ovf ? rfct_pkg::FILL_W'(rfct_pkg::MAX_OUT - 1)
                             : rfct_pkg::FILL_W'(rfct_pkg::MAX_OUT);
    assign o_cmd_ready = (r_state == S_IDLE);
    assign out_load  = !stall && ((emit_req && r_hold_v) || flush_req);

    // result requests, pushes and table writes per state
    always_comb begin
        emit_req  = 1'b0;
        emit_kind = rfct_pkg::KIND_ACC;
        emit_task = '0;
        flush_req = 1'b0;
        fifo_we   = 1'b0;
        fifo_wd   = r_idx;
        cnt_we    = 1'b0;
        cnt_wa    = r_head_e;
        cnt_wd    = cnt_w - 1'b1;
        off_we    = 1'b0;
        task_we   = 1'b0;
        unique case (r_state)
            S_ENQ_LOOP: off_we = (r_i != r_cmd.start);
            S_ENQ_FIN: begin
                emit_req  = 1'b1;
                emit_kind = rfct_pkg::KIND_ACC;
                task_we   = 1'b1;
                cnt_we    = 1'b1;
                cnt_wa    = r_cmd.start;
                cnt_wd    = r_cmd.span_cnt;
                fifo_we   = r_cmd.local_hit && push_ok;
                fifo_wd   = r_cmd.local_idx;
            end
            S_SCAN: begin
                fifo_we = r_window[r_i] && r_pending[r_i] && push_ok;
                fifo_wd = r_i;
            end
            S_DRN_CNT: begin
                if (cnt_w == '0) begin
                    fifo_we = push_ok;
                end else begin
                    cnt_we = 1'b1;
                    if (cnt_w == CW'(1)) begin
                        emit_req  = 1'b1;
                        emit_kind = rfct_pkg::KIND_DONE;
                        emit_task = r_task_rd;
                    end
                end
            end
            S_POLL_END: begin
                if (r_ovf) begin
                    emit_req  = 1'b1;
                    emit_kind = rfct_pkg::KIND_OVF;
                end else if (r_nres == '0) begin
                    emit_req  = 1'b1;
                    emit_kind = rfct_pkg::KIND_NONE;
                end
            end
            S_ONE: begin
                emit_req  = 1'b1;
                emit_kind = r_one_kind;
            end
            S_FLUSH: flush_req = 1'b1;
            default: ;
        endcase
        stall = (emit_req && r_hold_v && !slot_free) || (flush_req && !slot_free);
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_window  <= '0;
            r_pending <= '0;
            r_fill    <= '0;
            r_head    <= '0;
            r_open    <= '0;
            r_ovf     <= 1'b0;
            r_hold_v  <= 1'b0;
            r_out_v   <= 1'b0;
            r_cnt_vld <= '0;
            r_off_vld <= '0;
        end else begin
            if (r_out_v && o_out.ready && !out_load) r_out_v <= 1'b0;
            if (!stall) begin
                if (emit_req) begin
                    if (r_hold_v) begin
                        r_out_v    <= 1'b1;
                        r_out_kind <= r_hold_kind;
                        r_out_task <= r_hold_task;
                        r_out_last <= 1'b0;
                    end
                    r_hold_v    <= 1'b1;
                    r_hold_kind <= emit_kind;
                    r_hold_task <= emit_task;
                end
                if (flush_req) begin
                    r_out_v    <= 1'b1;
                    r_out_kind <= r_hold_kind;
                    r_out_task <= r_hold_task;
                    r_out_last <= 1'b1;
                    r_hold_v   <= 1'b0;
                end
                if (cnt_we) r_cnt_vld[cnt_wa] <= 1'b1;
                if (off_we) r_off_vld[r_i] <= 1'b1;

                unique case (r_state)
                    S_IDLE: begin
                        if (i_cmd_valid) begin
                            r_cmd <= i_cmd;
                            r_i   <= (i_cmd.op == rfct_pkg::OP_POLL) ? '0 : i_cmd.start;
                            r_ovf <= 1'b0;
                            r_nres <= '0;
                            unique case (i_cmd.op)
                                rfct_pkg::OP_FLAG: r_window[i_cmd.start] <= 1'b1;
                                rfct_pkg::OP_REJ: begin
                                    r_one_kind <= rfct_pkg::KIND_REJ;
                                    r_state    <= S_ONE;
                                end
                                rfct_pkg::OP_ENQ: r_state <= S_ENQ_LOOP;
                                rfct_pkg::OP_POLL: begin
                                    if (r_open == '0) begin
                                        r_one_kind <= rfct_pkg::KIND_NONE;
                                        r_state    <= S_ONE;
                                    end else begin
                                        r_state <= S_SCAN;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    S_ENQ_LOOP: begin
                        r_pending[r_i] <= 1'b1;
                        if (r_i == r_cmd.stop) r_state <= S_ENQ_FIN;
                        else r_i <= r_i + 1'b1;
                    end
                    S_ENQ_FIN: begin
                        if (r_open < rfct_pkg::OPEN_MAX) r_open <= r_open + 1'b1;
                        if (r_cmd.local_hit) begin
                            r_pending[r_cmd.local_idx] <= 1'b0;
                            if (push_ok) r_fill <= r_fill + 1'b1;
                        end
                        if (r_cmd.local_hit && !push_ok) begin
                            r_one_kind <= rfct_pkg::KIND_OVF;
                            r_state    <= S_ONE;
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end
                    S_SCAN: begin
                        if (r_window[r_i] && r_pending[r_i]) begin
                            if (push_ok) begin
                                r_fill         <= r_fill + 1'b1;
                                r_pending[r_i] <= 1'b0;
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                        r_i <= r_i + 1'b1;
                        if (r_i == FW'(FB - 1)) r_state <= S_DRN_INIT;
                    end
                    S_DRN_INIT: begin
                        r_todo  <= r_fill;
                        r_state <= S_DRN_POP;
                    end
                    S_DRN_POP: begin
                        if (r_todo == '0 || r_nres >= limit) begin
                            r_state <= S_POLL_END;
                        end else begin
                            r_head  <= r_head + 1'b1;
                            r_fill  <= r_fill - 1'b1;
                            r_todo  <= r_todo - 1'b1;
                            r_state <= S_DRN_OFF;
                        end
                    end
                    S_DRN_OFF: begin
                        r_idx   <= r_fifo_rd;
                        r_state <= S_DRN_HEAD;
                    end
                    S_DRN_HEAD: begin
                        r_head_e <= head_e_w;
                        r_state  <= S_DRN_CNT;
                    end
                    S_DRN_CNT: begin
                        if (fifo_we) r_fill <= r_fill + 1'b1;
                        if (cnt_w == CW'(1)) begin
                            r_nres <= r_nres + 1'b1;
                            if (r_open != '0) r_open <= r_open - 1'b1;
                        end
                        r_state <= S_DRN_POP;
                    end
                    S_POLL_END: r_state <= S_FLUSH;
                    S_ONE:      r_state <= S_FLUSH;
                    S_FLUSH:    r_state <= S_IDLE;
                    default:    r_state <= S_IDLE;
                endcase
            end
        end
    end

    // ready FIFO storage
    always_ff @(posedge i_clk) begin
        if (fifo_we && !stall) m_fifo[tail] <= fifo_wd;
        r_fifo_rd <= m_fifo[r_head];
    end

    // back-offset table
    always_ff @(posedge i_clk) begin
        if (off_we && !stall) m_off[r_i] <= r_i - r_cmd.start;
        r_off_rd   <= m_off[r_fifo_rd];
        r_off_rd_v <= r_off_vld[r_fifo_rd];
    end

    // count table; read data held while the update waits on the output
    always_ff @(posedge i_clk) begin
        if (cnt_we && !stall) m_cnt[cnt_wa] <= cnt_wd;
        if (r_state == S_DRN_HEAD) begin
            r_cnt_rd   <= m_cnt[head_e_w];
            r_cnt_rd_v <= r_cnt_vld[head_e_w];
        end
    end

    // task id table
    always_ff @(posedge i_clk) begin
        if (task_we && !stall) m_task[r_cmd.start] <= r_cmd.task_id;
        if (r_state == S_DRN_HEAD) r_task_rd <= m_task[head_e_w];
    end

    assign o_out.valid     = r_out_v;
    assign o_out.kind      = r_out_kind;
    assign o_out.done_task = r_out_task;
    assign o_out.last      = r_out_last;
    assign o_stat.fill     = r_fill;
    assign o_stat.open_cnt = r_open;
endmodule

@@ hw/rtl/range_flag_completion_tracker.sv @@
// ----------------------------------------------------------------------------
// range_flag_completion_tracker
// Tracks waits on ranges of remote-rank flag bits and reports finished tasks.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : request beats (enqueue wait, flag arrival, poll). type 3 is dropped.
//   o_out : result beats; every request that yields results ends with last=1.
//           Flag beats and type 3 yield nothing.
//   i_cfg_*: register writes (own rank, rank count); the user must make them
//            only while idle; the block itself does not enforce it.
// Back end (one request at a time): a flag is applied in the idle state.
//   enqueue   : mark each awaited bit pending in turn, then finish and flush.
//   poll      : with open waits, a scan of all 64 flag bits, then for each
//               drained FIFO entry pop, offset read, count/task read, update;
//               the scan and this table read chain set the poll time.
// The front registers and classifies beats; a 2-entry command queue lets it
// keep accepting while the back end works. Results pass through a one-beat
// hold (to mark last) and an output register; a stalled receiver halts the back
// end and, when the queue fills, the front. Synchronous active-low reset clears
// flags, counts, FIFO and config (own rank 0, rank count 2); task ids need none.
// ----------------------------------------------------------------------------
`include "range_flag_completion_tracker_macros.svh"

module range_flag_completion_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rfct_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rfct_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    rfct_in_if.sink                            i_in,
    rfct_out_if.source                         o_out
);
    logic [3:0]           r_own_rank;
    logic [4:0]           r_rank_count;
    logic                 f_valid;
    rfct_pkg::t_cmd       f_cmd;
    logic                 f_ready;
    logic                 q_valid;
    rfct_pkg::t_cmd       q_cmd;
    logic                 q_ready;
    rfct_pkg::t_back_stat stat;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_rank   <= 4'd0;
            r_rank_count <= 5'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rfct_pkg::CFG_OWN_RANK:   r_own_rank   <= i_cfg_data[3:0];
                rfct_pkg::CFG_RANK_COUNT: r_rank_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rfct_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_own_rank   (r_own_rank),
        .i_rank_count (r_rank_count),
        .i_in         (i_in),
        .o_cmd_valid  (f_valid),
        .o_cmd        (f_cmd),
        .i_cmd_ready  (f_ready)
    );

    rfct_cmd_q u_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_cmd   (f_cmd),
        .o_push_ready (f_ready),
        .o_pop_valid  (q_valid),
        .o_pop_cmd    (q_cmd),
        .i_pop_ready  (q_ready)
    );

    rfct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .o_out       (o_out),
        .o_stat      (stat)
    );

    // FIFO never holds more entries than the flag store has bits
    `RFCT_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, stat.fill <= rfct_pkg::FILL_W'(rfct_pkg::FLAG_BITS), "ready FIFO fill above capacity")
    // only completions carry a task id
    `RFCT_ASSERT_IMPL(a_task_zero, i_clk, i_rst_n, o_out.valid && (o_out.kind != rfct_pkg::KIND_DONE), o_out.done_task == '0, "task id on non-completion beat")
    // a rejection is the only result of its request
    `RFCT_ASSERT_IMPL(a_rej_last, i_clk, i_rst_n, o_out.valid && (o_out.kind == rfct_pkg::KIND_REJ), o_out.last, "rejection not marked last")
endmodule
